// File: rtl/byte_pair_histogram_log_scale_top_assert.svh
// assertion macros shared by the histogram rtl
`ifndef BYTE_PAIR_HISTOGRAM_LOG_SCALE_TOP_ASSERT_SVH
`define BYTE_PAIR_HISTOGRAM_LOG_SCALE_TOP_ASSERT_SVH

// same-cycle implication
`define BPH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bph assertion failed");

// next-cycle implication
`define BPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bph assertion failed");

`endif

// File: rtl/bph_pkg.sv
`timescale 1ns / 1ps
package bph_pkg;
	localparam int SYM_BITS   = 8;
	localparam int ADDR_BITS  = 2 * SYM_BITS;
	localparam int COUNT_BITS = 32;
	localparam int FRAC_BITS  = 10;
	localparam int EXP_BITS   = 6;
	localparam int LOG_BITS   = EXP_BITS + FRAC_BITS;
	localparam int MANT_BITS  = 31;
	localparam int NUM_BITS   = LOG_BITS + 8;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_DATA  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;
endpackage

// File: rtl/bph_req_if.sv
`timescale 1ns / 1ps
interface bph_req_if import bph_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [SYM_BITS-1:0] data_byte;
	logic [SYM_BITS-1:0] bin_x;
	logic [SYM_BITS-1:0] bin_y;

	modport source (output valid, mode, data_byte, bin_x, bin_y, input ready);
	modport sink (input valid, mode, data_byte, bin_x, bin_y, output ready);
endinterface

// File: rtl/bph_rsp_if.sv
`timescale 1ns / 1ps
interface bph_rsp_if import bph_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] bin_count;
	logic [7:0]            brightness;

	modport source (output valid, bin_count, brightness, input ready);
	modport sink (input valid, bin_count, brightness, output ready);
endinterface

// File: rtl/bph_ram.sv
`timescale 1ns / 1ps
module bph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/byte_pair_histogram_log_scale_top.sv
`timescale 1ns / 1ps
// byte pair histogram with log scaled readout
// req channel: mode 0 clears the store, mode 1 pushes a stream byte, mode 2
// reads bin (bin_x, bin_y); mode 3 is ignored. rsp channel carries one word
// for each read: the bin count and its brightness.
// one item is worked at a time; req.ready is high only while idle.
// a data byte with no pair yet goes straight back to idle; otherwise a ram read
// is followed by a write of the saturated increment. a read takes a ram read, then
// two log2 runs on the shared 31x31 squarer (normalize shifts, then a square and
// a bit step per fraction bit, each) and a restoring divide; a zero peak skips
// straight to the output.
// after reset and after each start word a clearing pass writes zero to all
// 65536 bins, one a cycle, and req.ready stays low until the pass is done.
// the result sits in an output register; while rsp.ready is low the block
// still takes new words and only a finished read waits for the register.
module byte_pair_histogram_log_scale_top import bph_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	bph_req_if.sink   req,
	bph_rsp_if.source rsp
);
	`include "byte_pair_histogram_log_scale_top_assert.svh"

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_UPD, ST_RDW, ST_NORM, ST_MUL, ST_FRAC, ST_DIV, ST_OUT
	} state_t;

	state_t                state_q;
	logic [ADDR_BITS-1:0]  clr_addr_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [SYM_BITS-1:0]   last_q;
	logic                  have_last_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  zero_q;
	logic                  log_sel_q;
	logic [COUNT_BITS:0]   norm_q;
	logic [EXP_BITS-1:0]   exp_q;
	logic [MANT_BITS-1:0]  mant_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [3:0]            bit_q;
	logic [2*MANT_BITS-1:0] prod_q;
	logic [LOG_BITS-1:0]   lm_q;
	logic [NUM_BITS-1:0]   num_q;
	logic [LOG_BITS-1:0]   rem_q;
	logic [4:0]            div_cnt_q;
	logic                  rsp_valid_q;
	logic [COUNT_BITS-1:0] rsp_count_q;
	logic [7:0]            rsp_bright_q;

	logic                  we;
	logic [ADDR_BITS-1:0]  waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [ADDR_BITS-1:0]  raddr;
	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] inc_val;
	logic [MANT_BITS:0]    sq;
	logic [FRAC_BITS-1:0]  frac_next;
	logic [LOG_BITS-1:0]   log_val;
	logic [LOG_BITS:0]     trial;
	logic                  req_fire;

	bph_ram #(.WIDTH(COUNT_BITS), .DEPTH(2 ** ADDR_BITS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req.ready     = (state_q == ST_IDLE);
	assign req_fire      = req.valid && req.ready;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.bin_count  = rsp_count_q;
	assign rsp.brightness = rsp_bright_q;

	always_comb begin
		inc_val = (rdata == '1) ? rdata : rdata + COUNT_BITS'(1);
		we      = (state_q == ST_CLEAR) || (state_q == ST_UPD);
		waddr   = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
		wdata   = (state_q == ST_CLEAR) ? '0 : inc_val;
		raddr   = (mode_t'(req.mode) == MODE_READ) ? {req.bin_y, req.bin_x}
			: {req.data_byte, last_q};
		// square is q1.30 times q1.30, truncated to q2.30 (32 bits kept)
		sq        = prod_q[2*MANT_BITS-1:MANT_BITS-1];
		frac_next = frac_q;
		if (sq[MANT_BITS]) begin
			frac_next[bit_q] = 1'b1;
		end
		log_val = {exp_q, frac_next};
		trial   = {rem_q, num_q[NUM_BITS-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			last_q      <= '0;
			have_last_q <= 1'b0;
			peak_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != ST_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						addr_q <= raddr;
						case (mode_t'(req.mode))
							MODE_START: begin
								clr_addr_q  <= '0;
								last_q      <= '0;
								have_last_q <= 1'b0;
								peak_q      <= '0;
								state_q     <= ST_CLEAR;
							end
							MODE_DATA: begin
								last_q      <= req.data_byte;
								have_last_q <= 1'b1;
								if (have_last_q) begin
									state_q <= ST_UPD;
								end
							end
							MODE_READ: state_q <= ST_RDW;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_UPD: begin
					if (inc_val > peak_q) begin
						peak_q <= inc_val;
					end
					state_q <= ST_IDLE;
				end
				ST_RDW: begin
					cnt_q     <= rdata;
					zero_q    <= (peak_q == '0);
					norm_q    <= {1'b0, peak_q} + (COUNT_BITS + 1)'(1);
					exp_q     <= EXP_BITS'(COUNT_BITS);
					log_sel_q <= 1'b0;
					state_q   <= (peak_q == '0) ? ST_OUT : ST_NORM;
				end
				ST_NORM: begin
					// shift until the leading one reaches the top bit
					if (norm_q[COUNT_BITS]) begin
						mant_q  <= norm_q[COUNT_BITS -: MANT_BITS];
						frac_q  <= '0;
						bit_q   <= 4'(FRAC_BITS - 1);
						state_q <= ST_MUL;
					end else begin
						norm_q <= norm_q << 1;
						exp_q  <= exp_q - EXP_BITS'(1);
					end
				end
				ST_MUL: begin
					prod_q  <= {{MANT_BITS{1'b0}}, mant_q} * {{MANT_BITS{1'b0}}, mant_q};
					state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					frac_q <= frac_next;
					mant_q <= sq[MANT_BITS] ? sq[MANT_BITS:1] : sq[MANT_BITS-1:0];
					if (bit_q == '0) begin
						if (!log_sel_q) begin
							lm_q      <= log_val;
							norm_q    <= {1'b0, cnt_q} + (COUNT_BITS + 1)'(1);
							exp_q     <= EXP_BITS'(COUNT_BITS);
							log_sel_q <= 1'b1;
							state_q   <= ST_NORM;
						end else begin
							num_q     <= {log_val, 8'd0};
							rem_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end
					end else begin
						bit_q   <= bit_q - 4'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					// restoring divide, quotient shifts into num_q
					if (trial >= {1'b0, lm_q}) begin
						rem_q <= LOG_BITS'(trial - {1'b0, lm_q});
						num_q <= {num_q[NUM_BITS-2:0], 1'b1};
					end else begin
						rem_q <= trial[LOG_BITS-1:0];
						num_q <= {num_q[NUM_BITS-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(NUM_BITS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_count_q <= cnt_q;
						if (zero_q) begin
							rsp_bright_q <= '0;
						end else if (num_q > NUM_BITS'(255)) begin
							rsp_bright_q <= 8'd255;
						end else begin
							rsp_bright_q <= num_q[7:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BPH_ASSERT_NOW(a_clear_writes_zero, clk, arst_n,
		state_q == ST_CLEAR, we && wdata == '0)
	`BPH_ASSERT_NEXT(a_peak_follows_write, clk, arst_n,
		we && state_q == ST_UPD, peak_q >= $past(wdata))
	`BPH_ASSERT_NEXT(a_clear_ends, clk, arst_n,
		state_q == ST_CLEAR && clr_addr_q == '1, state_q == ST_IDLE)
endmodule

// File: bench/bph_scoreboard.sv
`timescale 1ns / 1ps
module bph_scoreboard import bph_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bph_req_if   req,
	bph_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	typedef struct packed {
		logic [COUNT_BITS-1:0] bin_count;
		logic [7:0]            brightness;
	} bin_reading_t;

	logic [COUNT_BITS-1:0] pair_tally [int unsigned];
	logic [7:0]            prev_sym;
	logic                  prev_valid;
	logic [COUNT_BITS-1:0] top_tally;
	bin_reading_t          readings_due [$];

	// log2(c + 1) in q6.10
	function automatic logic [LOG_BITS-1:0] log2_succ(input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS:0]   x;
		logic [63:0]           m;
		int                    e;
		logic [LOG_BITS-1:0]   acc;
		x = {1'b0, c} + 1'b1;
		e = 0;
		for (int i = 0; i <= COUNT_BITS; i++)
			if (x[i]) e = i;
		if (e >= 30) m = 64'(x) >> (e - 30);
		else m = 64'(x) << (30 - e);
		acc = LOG_BITS'(e) << FRAC_BITS;
		for (int k = FRAC_BITS - 1; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				acc[k] = 1'b1;
				m = m >> 1;
			end
		end
		return acc;
	endfunction

	function automatic logic [7:0] shade_of(input logic [COUNT_BITS-1:0] c);
		logic [63:0] lc, lm, q;
		if (top_tally == 0) return 8'd0;
		lm = 64'(log2_succ(top_tally));
		lc = 64'(log2_succ(c));
		if (lm == 0) return 8'd0;
		q = (lc * 256) / lm;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("%0t mismatch on %s: expected %0d got %0d", $realtime, what, want, got);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		prev_sym = '0;
		prev_valid = 1'b0;
		top_tally = '0;
	end

	always @(posedge clk) begin
		int unsigned           idx;
		logic [COUNT_BITS-1:0] v;
		bin_reading_t          r;
		if (arst_n && req.valid && req.ready) begin
			case (mode_t'(req.mode))
				MODE_START: begin
					pair_tally.delete();
					prev_sym = '0;
					prev_valid = 1'b0;
					top_tally = '0;
				end
				MODE_DATA: begin
					if (prev_valid) begin
						idx = {req.data_byte, prev_sym};
						v = pair_tally.exists(idx) ? pair_tally[idx] : '0;
						if (v != '1) v = v + 1'b1;
						pair_tally[idx] = v;
						if (v > top_tally) top_tally = v;
					end
					prev_sym = req.data_byte;
					prev_valid = 1'b1;
				end
				MODE_READ: begin
					idx = {req.bin_y, req.bin_x};
					r.bin_count = pair_tally.exists(idx) ? pair_tally[idx] : '0;
					r.brightness = shade_of(r.bin_count);
					readings_due.push_back(r);
				end
				default: ;
			endcase
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (readings_due.size() == 0) begin
				report("unexpected rsp word", 64'd0, 64'(rsp.bin_count));
			end else begin
				r = readings_due.pop_front();
				if (rsp.bin_count !== r.bin_count) report("bin_count", r.bin_count, rsp.bin_count);
				if (rsp.brightness !== r.brightness)
					report("brightness", r.brightness, rsp.brightness);
			end
		end
		pending <= readings_due.size();
	end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import bph_pkg::*;

	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   calm;
	int   quiet_cycles;

	bph_req_if req ();
	bph_rsp_if rsp ();

	byte_pair_histogram_log_scale_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	bph_scoreboard sb (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	task automatic push_word(input mode_t m, input logic [7:0] b, input logic [7:0] x,
			input logic [7:0] y);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.mode <= m;
		req.data_byte <= b;
		req.bin_x <= x;
		req.bin_y <= y;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_word(MODE_DATA, b, 8'($urandom), 8'($urandom));
	endtask

	task automatic push_read(input logic [7:0] x, input logic [7:0] y);
		push_word(MODE_READ, 8'($urandom), x, y);
	endtask

	task automatic push_start();
		push_word(MODE_START, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// rsp side holds ready low for a draw_gap() pause before each word
	initial begin
		int gap;
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		logic [7:0] alpha [8];
		int         n_alpha;
		int         pick;
		quiet_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.mode <= MODE_NONE;
		req.data_byte <= '0;
		req.bin_x <= '0;
		req.bin_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty store: peak zero reads, unused mode; then bytes 0 and 255, corner reads, a start and a new pair
		push_read(8'd0, 8'd0);
		push_read(8'd255, 8'd255);
		push_word(MODE_NONE, 8'hff, 8'hff, 8'hff);
		push_byte(8'd0);
		push_read(8'd0, 8'd0);
		push_byte(8'd255);
		push_byte(8'd0);
		push_byte(8'd255);
		push_byte(8'd255);
		push_byte(8'd255);
		push_read(8'd0, 8'd255);
		push_read(8'd255, 8'd0);
		push_read(8'd255, 8'd255);
		push_read(8'd0, 8'd0);
		push_word(MODE_NONE, 8'h00, 8'h00, 8'h00);
		push_read(8'd255, 8'd255);
		push_start();
		push_read(8'd255, 8'd255);
		push_byte(8'h55);
		push_byte(8'haa);
		push_read(8'h55, 8'haa);

		for (int phase = 0; phase < 4; phase++) begin
			calm = (phase == 2);
			push_start();
			n_alpha = $urandom_range(2, 6);
			for (int i = 0; i < n_alpha; i++) alpha[i] = 8'($urandom);
			for (int i = 0; i < 210; i++) begin
				if (phase == 1 && i == 100) begin
					req.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				pick = $urandom_range(0, 99);
				if (pick < 78)
					push_byte(alpha[$urandom_range(0, n_alpha - 1)]);
				else if (pick < 88)
					push_read(alpha[$urandom_range(0, n_alpha - 1)],
						alpha[$urandom_range(0, n_alpha - 1)]);
				else if (pick < 92)
					push_read(8'($urandom), 8'($urandom));
				else if (pick < 97)
					push_byte(8'($urandom));
				else
					push_word(MODE_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
			end
		end

		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end
endmodule
